[rtl/lcb_pkg.sv]
// ----------------------------------------------------------------------------
// lcb_pkg
// Types, codes and constants shared by the LRU cache cells and top level.
// ----------------------------------------------------------------------------
package lcb_pkg;

  localparam int unsigned SLOTS_DEF = 32;
  localparam int unsigned IDX_W     = 8;
  localparam int unsigned CNT_W     = 9;
  localparam int unsigned SUB_W     = 40;

  localparam logic [1:0] ACT_RESOLVE = 2'd0;
  localparam logic [1:0] ACT_PRUNE   = 2'd1;
  localparam logic [1:0] ACT_CLEAR   = 2'd2;
  localparam logic [1:0] ACT_RELEASE = 2'd3;

  localparam logic [2:0] ST_UNSUPPORTED = 3'd0;
  localparam logic [2:0] ST_STALE       = 3'd1;
  localparam logic [2:0] ST_HIT         = 3'd2;
  localparam logic [2:0] ST_INSERTED    = 3'd3;
  localparam logic [2:0] ST_TOO_LARGE   = 3'd4;
  localparam logic [2:0] ST_DONE        = 3'd5;

  localparam logic [1:0] REG_MAX_ENTRIES = 2'd0;
  localparam logic [1:0] REG_MAX_BYTES   = 2'd1;
  localparam logic [1:0] REG_IDLE        = 2'd2;

  localparam logic [5:0]  RST_MAX_ENTRIES = 6'd32;
  localparam logic [31:0] RST_MAX_BYTES   = 32'd4194304;
  localparam logic [31:0] RST_IDLE        = 32'd30000;

  typedef enum logic [2:0] {
    P_RESOLVE = 3'd0,
    P_PRUNE   = 3'd1,
    P_CLEAR   = 3'd2,
    P_RELEASE = 3'd3,
    P_LRU     = 3'd4,
    P_FREE    = 3'd5
  } pass_t;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_TOUCH = 2'd1,
    OP_DROP  = 2'd2,
    OP_WRITE = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] owner_id;
    logic [1:0]  backend;
    logic [63:0] asset_sig;
    logic [63:0] request_sig;
    logic [63:0] capability_sig;
    logic [63:0] generation;
    logic [31:0] time_ms;
    logic        data_current;
    logic [31:0] item_bytes;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  slot;
    logic [5:0]  evicted;
    logic [5:0]  entry_count;
    logic [31:0] total_bytes;
  } result_t;

  typedef struct packed {
    op_t              op;
    pass_t            mode;
    logic [IDX_W-1:0] slot;
    logic [15:0]      owner;
    logic             backend;
    logic [63:0]      asig;
    logic [63:0]      rsig;
    logic [63:0]      csig;
    logic [63:0]      gen;
    logic [31:0]      now;
    logic [31:0]      idle;
    logic             current;
    logic [31:0]      item;
    logic [63:0]      seq;
  } cmd_t;

  typedef struct packed {
    logic [SUB_W-1:0] sub;
    logic [CNT_W-1:0] removed;
    logic [CNT_W-1:0] cnt;
    logic             hit;
    logic [IDX_W-1:0] hit_slot;
    logic             found;
    logic [63:0]      min_seq;
    logic [IDX_W-1:0] min_slot;
  } carry_t;

endpackage

[rtl/lcb_cell.sv]
// ----------------------------------------------------------------------------
// lcb_cell
// One cache entry; processes the pass word and hands it to the next cell.
// ----------------------------------------------------------------------------
module lcb_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  lcb_pkg::cmd_t   cmd,
  input  logic           tok_in,
  input  lcb_pkg::carry_t carry_in,
  output logic           tok_out,
  output lcb_pkg::carry_t carry_out
);
  import lcb_pkg::*;

  logic        valid;
  logic [15:0] e_owner;
  logic        e_backend;
  logic [63:0] e_asig;
  logic [63:0] e_rsig;
  logic [63:0] e_csig;
  logic [63:0] e_gen;
  logic [63:0] e_seq;
  logic [31:0] e_time;
  logic [31:0] e_bytes;

  logic   idle;
  logic   key_hit;
  logic   drop;
  logic   mine;
  carry_t carry_next;

  assign mine = (cmd.slot == IDX_W'(IDX));
  assign idle = {1'b0, cmd.now} >= ({1'b0, e_time} + {1'b0, cmd.idle});
  assign key_hit = (e_owner == cmd.owner) && (e_backend == cmd.backend) &&
                   (e_asig == cmd.asig) && (e_rsig == cmd.rsig) &&
                   (e_csig == cmd.csig) && (e_gen == cmd.gen);

  always_comb begin
    drop = 1'b0;
    case (cmd.mode)
      P_RESOLVE: drop = (e_gen != cmd.gen) || idle ||
                        ((e_owner == cmd.owner) && (!cmd.current || e_asig != cmd.asig));
      P_PRUNE:   drop = idle;
      P_CLEAR:   drop = 1'b1;
      P_RELEASE: drop = (e_owner == cmd.owner);
      default:   drop = 1'b0;
    endcase
    drop = drop && valid;
  end

  always_comb begin
    carry_next = carry_in;
    case (cmd.mode)
      P_LRU: begin
        if (valid && (!carry_in.found || e_seq < carry_in.min_seq)) begin
          carry_next.found    = 1'b1;
          carry_next.min_seq  = e_seq;
          carry_next.min_slot = IDX_W'(IDX);
          carry_next.sub      = SUB_W'(e_bytes);
        end
      end
      P_FREE: begin
        if (!valid && !carry_in.found) begin
          carry_next.found    = 1'b1;
          carry_next.min_slot = IDX_W'(IDX);
        end
      end
      default: begin
        if (drop) begin
          carry_next.sub     = carry_in.sub + SUB_W'(e_bytes);
          carry_next.removed = carry_in.removed + 1'b1;
        end else if (valid) begin
          carry_next.cnt = carry_in.cnt + 1'b1;
          if (cmd.mode == P_RESOLVE && cmd.current && key_hit && !carry_in.hit) begin
            carry_next.hit      = 1'b1;
            carry_next.hit_slot = IDX_W'(IDX);
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= 1'b0;
      tok_out <= 1'b0;
    end else begin
      tok_out <= tok_in;
      if (tok_in && drop) begin
        valid <= 1'b0;
      end
      if (mine && cmd.op == OP_DROP) begin
        valid <= 1'b0;
      end
      if (mine && cmd.op == OP_WRITE) begin
        valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    carry_out <= carry_next;
    if (mine && (cmd.op == OP_TOUCH || cmd.op == OP_WRITE)) begin
      e_seq  <= cmd.seq;
      e_time <= cmd.now;
    end
    if (mine && cmd.op == OP_WRITE) begin
      e_owner   <= cmd.owner;
      e_backend <= cmd.backend;
      e_asig    <= cmd.asig;
      e_rsig    <= cmd.rsig;
      e_csig    <= cmd.csig;
      e_gen     <= cmd.gen;
      e_bytes   <= cmd.item;
    end
  end

endmodule

[rtl/lru_cache_byte_budget_idle_expiry.sv]
// ----------------------------------------------------------------------------
// lru_cache_byte_budget_idle_expiry
// Fully associative LRU cache with count and byte budgets and idle expiry.
//
//   channel  | signals                        | handshake
//   request  | start, busy, req               | taken when start && !busy
//   result   | done, result                   | one-cycle strobe, no stall
//   config   | cfg_we, cfg_index, cfg_data    | written when cfg_we
//
// Each pass walks a word down the row of cells, one cell a cycle. A resolve
// takes a sweep pass, then, on a current miss, one LRU pass per eviction and
// a free-slot pass on insert; a resolve for an unsupported backend takes none.
// Other actions take one pass. Reset is synchronous and empties the cache.
// ----------------------------------------------------------------------------
module lru_cache_byte_budget_idle_expiry #(
  parameter int unsigned SLOTS = lcb_pkg::SLOTS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  lcb_pkg::req_t    req,
  output logic             done,
  output lcb_pkg::result_t result,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [31:0]      cfg_data
);
  import lcb_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SWEEP = 5'b00010,
    S_EVCHK = 5'b00100,
    S_LRU   = 5'b01000,
    S_FREE  = 5'b10000
  } state_t;

  state_t      state;
  cmd_t        cmd;
  logic        launch;
  logic [1:0]  act;
  logic [31:0] bytes;
  logic [63:0] acc;
  logic [CNT_W-1:0] n;
  logic [CNT_W-1:0] removed;
  logic [5:0]  max_entries;
  logic [31:0] max_bytes;
  logic [31:0] idle_lifetime;

  logic   tok   [SLOTS+1];
  carry_t carry [SLOTS+1];

  logic [CNT_W-1:0] maxe;
  logic [31:0]      maxb;
  logic [31:0]      bytes_left;
  logic             evict_need;
  logic             too_big;
  logic             pass_end;
  carry_t           last;

  assign tok[0]   = launch;
  assign carry[0] = '0;
  assign last     = carry[SLOTS];
  assign pass_end = tok[SLOTS];

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    lcb_cell #(.IDX(i)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .tok_in    (tok[i]),
      .carry_in  (carry[i]),
      .tok_out   (tok[i+1]),
      .carry_out (carry[i+1])
    );
  end

  always_comb begin
    if (max_entries == '0) begin
      maxe = CNT_W'(1);
    end else if (CNT_W'(max_entries) > CNT_W'(SLOTS)) begin
      maxe = CNT_W'(SLOTS);
    end else begin
      maxe = CNT_W'(max_entries);
    end
    maxb       = (max_bytes == '0) ? 32'd1 : max_bytes;
    bytes_left = (last.sub >= SUB_W'(bytes)) ? 32'd0 : (bytes - last.sub[31:0]);
    evict_need = (n != '0) && ((n >= maxe) ||
                 (({1'b0, bytes} + {1'b0, cmd.item}) > {1'b0, maxb}));
    too_big    = cmd.item > maxb;
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries   <= RST_MAX_ENTRIES;
      max_bytes     <= RST_MAX_BYTES;
      idle_lifetime <= RST_IDLE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_ENTRIES: max_entries   <= cfg_data[5:0];
        REG_MAX_BYTES:   max_bytes     <= cfg_data;
        REG_IDLE:        idle_lifetime <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      launch  <= 1'b0;
      done    <= 1'b0;
      bytes   <= '0;
      acc     <= '0;
      n       <= '0;
      removed <= '0;
      cmd.op  <= OP_NONE;
    end else begin
      launch <= 1'b0;
      done   <= 1'b0;
      cmd.op <= OP_NONE;
      case (state)
        S_IDLE: begin
          if (start) begin
            act         <= req.action;
            removed     <= '0;
            cmd.owner   <= req.owner_id;
            cmd.backend <= req.backend[0];
            cmd.asig    <= req.asset_sig;
            cmd.rsig    <= req.request_sig;
            cmd.csig    <= req.capability_sig;
            cmd.gen     <= req.generation;
            cmd.now     <= req.time_ms;
            cmd.idle    <= (idle_lifetime == '0) ? 32'd1 : idle_lifetime;
            cmd.current <= req.data_current;
            cmd.item    <= (req.item_bytes == '0) ? 32'd1 : req.item_bytes;
            case (req.action)
              ACT_PRUNE:   cmd.mode <= P_PRUNE;
              ACT_CLEAR:   cmd.mode <= P_CLEAR;
              ACT_RELEASE: cmd.mode <= P_RELEASE;
              default:     cmd.mode <= P_RESOLVE;
            endcase
            if (req.action == ACT_RESOLVE && req.backend[1]) begin
              done   <= 1'b1;
              result <= '{ST_UNSUPPORTED, 5'd0, 6'd0, n[5:0], bytes};
            end else begin
              launch <= 1'b1;
              state  <= S_SWEEP;
            end
          end
        end
        S_SWEEP: begin
          if (pass_end) begin
            n       <= last.cnt;
            removed <= last.removed;
            bytes   <= (act == ACT_CLEAR) ? 32'd0 : bytes_left;
            if (act != ACT_RESOLVE) begin
              done   <= 1'b1;
              state  <= S_IDLE;
              result <= '{ST_DONE, 5'd0, last.removed[5:0], last.cnt[5:0],
                          (act == ACT_CLEAR) ? 32'd0 : bytes_left};
            end else if (!cmd.current) begin
              done   <= 1'b1;
              state  <= S_IDLE;
              result <= '{ST_STALE, 5'd0, last.removed[5:0], last.cnt[5:0], bytes_left};
            end else if (last.hit) begin
              cmd.op   <= OP_TOUCH;
              cmd.slot <= last.hit_slot;
              cmd.seq  <= acc + 64'd1;
              acc      <= acc + 64'd1;
              done     <= 1'b1;
              state    <= S_IDLE;
              result   <= '{ST_HIT, last.hit_slot[4:0], last.removed[5:0],
                            last.cnt[5:0], bytes_left};
            end else begin
              state <= S_EVCHK;
            end
          end
        end
        S_EVCHK: begin
          if (evict_need) begin
            cmd.mode <= P_LRU;
            launch   <= 1'b1;
            state    <= S_LRU;
          end else if (too_big) begin
            done   <= 1'b1;
            state  <= S_IDLE;
            result <= '{ST_TOO_LARGE, 5'd0, removed[5:0], n[5:0], bytes};
          end else begin
            cmd.mode <= P_FREE;
            launch   <= 1'b1;
            state    <= S_FREE;
          end
        end
        S_LRU: begin
          if (pass_end) begin
            cmd.op   <= OP_DROP;
            cmd.slot <= last.min_slot;
            bytes    <= bytes_left;
            n        <= n - 1'b1;
            removed  <= removed + 1'b1;
            state    <= S_EVCHK;
          end
        end
        S_FREE: begin
          if (pass_end) begin
            done  <= 1'b1;
            state <= S_IDLE;
            if (last.found) begin
              cmd.op   <= OP_WRITE;
              cmd.slot <= last.min_slot;
              cmd.seq  <= acc + 64'd1;
              acc      <= acc + 64'd1;
              n        <= n + 1'b1;
              bytes    <= bytes + cmd.item;
              result   <= '{ST_INSERTED, last.min_slot[4:0], removed[5:0],
                            6'(n + 1'b1), bytes + cmd.item};
            end else begin
              result <= '{ST_INSERTED, 5'd0, removed[5:0], n[5:0], bytes};
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/lcb_checker.sv]
// ----------------------------------------------------------------------------
// lcb_checker
// Port-level checks on the LRU cache request and result channels.
// ----------------------------------------------------------------------------
module lcb_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input lcb_pkg::result_t result
);
  import lcb_pkg::*;

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || done) else $error("request not taken");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) || $past(start)) else $error("result without request");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result while busy");

  a_status: assert property (@(posedge clk) disable iff (rst)
    done |-> result.status <= ST_DONE && result.entry_count <= 6'd32)
    else $error("result out of range");

endmodule

bind lru_cache_byte_budget_idle_expiry lcb_checker u_lcb_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
